FILE: rtl/tbcs_pkg.sv
package tbcs_pkg;

	// command codes
	typedef enum logic [1:0] {
		ACT_BYTE  = 2'd0,
		ACT_PILOT = 2'd1,
		ACT_PAUSE = 2'd2,
		ACT_NONE  = 2'd3
	} tbcs_action_t;

	// configuration register indexes
	localparam logic [1:0] REG_LOW_LEVEL  = 2'd0;
	localparam logic [1:0] REG_HIGH_LEVEL = 2'd1;
	localparam logic [1:0] REG_SPEED      = 2'd2;

	localparam int LEVEL_W   = 8;
	localparam int SPEED_W   = 4;
	localparam int DATA_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;

	localparam logic [LEVEL_W-1:0] LOW_LEVEL_RST  = 8'd0;
	localparam logic [LEVEL_W-1:0] HIGH_LEVEL_RST = 8'd255;
	localparam logic [SPEED_W-1:0] SPEED_RST      = 4'd3;

	// a byte is start bit, eight data bits and two stop bits, four units each
	localparam int UNITS_PER_BIT = 4;
	localparam int UNITS_MAX     = UNITS_PER_BIT * (1 + DATA_W + 2);
	localparam int LEN_W         = $clog2(UNITS_MAX + 1);

	// unit patterns, bit k set means unit k is high
	localparam logic [UNITS_PER_BIT-1:0] PAT_ZERO  = 4'b1100;
	localparam logic [UNITS_PER_BIT-1:0] PAT_ONE   = 4'b1010;
	localparam logic [1:0]               PAT_PILOT = 2'b10;
	localparam logic [1:0]               PAT_PAUSE = 2'b00;

	localparam int Q_DEPTH = 2;

	typedef struct packed {
		logic [UNITS_MAX-1:0] pat;
		logic [LEN_W-1:0]     len;
	} tbcs_desc_t;

endpackage

FILE: rtl/tbcs_cmd_if.sv
interface tbcs_cmd_if import tbcs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [DATA_W-1:0] data_byte;

	modport source (output valid, action, data_byte, input ready);
	modport sink (input valid, action, data_byte, output ready);
endinterface

FILE: rtl/tbcs_unit_if.sv
interface tbcs_unit_if import tbcs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] level;
	logic [SPEED_W-1:0] repeat_res;
	logic               last;

	modport source (output valid, level, repeat_res, last, input ready);
	modport sink (input valid, level, repeat_res, last, output ready);
endinterface

FILE: rtl/tbcs_cfg_if.sv
interface tbcs_cfg_if import tbcs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/tbcs_front.sv
module tbcs_front import tbcs_pkg::*; (
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  logic [1:0]        action,
	input  logic [DATA_W-1:0] data_byte,
	input  logic              q_ready,
	output logic              q_push,
	output tbcs_desc_t        q_desc
);

	tbcs_desc_t desc;
	logic       keep;

	always_comb begin
		desc = '0;
		keep = 1'b1;
		case (tbcs_action_t'(action))
			ACT_BYTE: begin
				desc.pat[UNITS_PER_BIT-1:0] = PAT_ZERO;
				for (int i = 0; i < DATA_W; i++) begin
					desc.pat[UNITS_PER_BIT*(i+1) +: UNITS_PER_BIT] =
						data_byte[i] ? PAT_ONE : PAT_ZERO;
				end
				desc.pat[UNITS_PER_BIT*(DATA_W+1) +: UNITS_PER_BIT] = PAT_ONE;
				desc.pat[UNITS_PER_BIT*(DATA_W+2) +: UNITS_PER_BIT] = PAT_ONE;
				desc.len = LEN_W'(UNITS_MAX);
			end
			ACT_PILOT: begin
				desc.pat[1:0] = PAT_PILOT;
				desc.len = LEN_W'(2);
			end
			ACT_PAUSE: begin
				desc.pat[1:0] = PAT_PAUSE;
				desc.len = LEN_W'(2);
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// unused code is taken and dropped
	assign cmd_ready = q_ready;
	assign q_push    = cmd_valid && q_ready && keep;
	assign q_desc    = desc;

endmodule

FILE: rtl/tbcs_queue.sv
module tbcs_queue import tbcs_pkg::*; #(
	parameter int DEPTH = Q_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tbcs_desc_t push_desc,
	output logic       push_ready,
	input  logic       pop,
	output logic       head_valid,
	output tbcs_desc_t head_desc
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tbcs_desc_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_desc  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/tbcs_back.sv
module tbcs_back import tbcs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  tbcs_desc_t         head_desc,
	output logic               pop,
	input  logic [LEVEL_W-1:0] low_level,
	input  logic [LEVEL_W-1:0] high_level,
	input  logic [SPEED_W-1:0] speed,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [LEVEL_W-1:0] level,
	output logic [SPEED_W-1:0] repeat_res,
	output logic               last
);

	logic [UNITS_MAX-1:0] cur_pat_q;
	logic [LEN_W-1:0]     cur_rem_q;
	logic                 out_valid_q;
	logic [LEVEL_W-1:0]   level_q;
	logic [SPEED_W-1:0]   repeat_q;
	logic                 last_q;

	logic                 have_cur;
	logic [UNITS_MAX-1:0] src_pat;
	logic [LEN_W-1:0]     src_len;
	logic                 src_valid;
	logic                 load;
	logic                 adv;

	assign have_cur  = cur_rem_q != '0;
	assign src_pat   = have_cur ? cur_pat_q : head_desc.pat;
	assign src_len   = have_cur ? cur_rem_q : head_desc.len;
	assign src_valid = have_cur || head_valid;
	assign load      = !out_valid_q || out_ready;
	assign adv       = load && src_valid;
	assign pop       = adv && !have_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cur_rem_q   <= '0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
			cur_rem_q   <= src_len - 1'b1;
		end else if (load) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			level_q   <= src_pat[0] ? high_level : low_level;
			repeat_q  <= speed;
			last_q    <= src_len == LEN_W'(1);
			cur_pat_q <= src_pat >> 1;
		end
	end

	assign out_valid  = out_valid_q;
	assign level      = level_q;
	assign repeat_res = repeat_q;
	assign last       = last_q;

endmodule

FILE: rtl/tape_bit_cell_serializer.sv
// channel | role   | payload                          | handshake
// cmd     | sink   | action[1:0], data_byte[7:0]      | valid/ready
// units   | source | level[7:0], repeat_res[3:0], last| valid/ready
// cfg     | sink   | index[1:0], data[7:0]            | valid/ready, ready always high
//
// one unit per cycle leaves the output register unless units stall; a byte command makes
// 44 units, pilot and pause make 2, all shifted out by the back end's unit shifter
// commands are taken while the command queue has room, also while units are stalled
// the unused action code is taken and dropped without any unit
// reset (arst_n low) empties the queue and the shifter, levels go to 0 and 255, speed to 3
// a stall on units holds the output register; the queue fills and then cmd.ready drops
module tape_bit_cell_serializer import tbcs_pkg::*; #(
	parameter int QUEUE_DEPTH = Q_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	tbcs_cmd_if.sink    cmd,
	tbcs_unit_if.source units,
	tbcs_cfg_if.sink    cfg
);

	// configuration registers
	logic [LEVEL_W-1:0] low_level_q;
	logic [LEVEL_W-1:0] high_level_q;
	logic [SPEED_W-1:0] speed_q;

	// front to queue
	logic       q_push;
	logic       q_ready;
	tbcs_desc_t q_desc;

	// queue to back
	logic       q_pop;
	logic       head_valid;
	tbcs_desc_t head_desc;

	// register writes land at once, indexes past the list are ignored
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_level_q  <= LOW_LEVEL_RST;
			high_level_q <= HIGH_LEVEL_RST;
			speed_q      <= SPEED_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LOW_LEVEL:  low_level_q  <= cfg.data[LEVEL_W-1:0];
				REG_HIGH_LEVEL: high_level_q <= cfg.data[LEVEL_W-1:0];
				REG_SPEED:      speed_q      <= cfg.data[SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// front end: decode the command into a unit pattern and a length
	tbcs_front u_front (
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.action    (cmd.action),
		.data_byte (cmd.data_byte),
		.q_ready   (q_ready),
		.q_push    (q_push),
		.q_desc    (q_desc)
	);

	// short queue of decoded commands between front and back
	tbcs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_desc  (q_desc),
		.push_ready (q_ready),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	// back end: shift out one unit per cycle into the output register unless units stall
	tbcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.pop        (q_pop),
		.low_level  (low_level_q),
		.high_level (high_level_q),
		.speed      (speed_q),
		.out_valid  (units.valid),
		.out_ready  (units.ready),
		.level      (units.level),
		.repeat_res (units.repeat_res),
		.last       (units.last)
	);

endmodule

FILE: rtl/tbcs_checker.sv
module tbcs_checker import tbcs_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_ready,
	input logic [1:0]         cmd_action,
	input logic               out_valid,
	input logic               out_ready,
	input logic [LEVEL_W-1:0] out_level,
	input logic [SPEED_W-1:0] out_repeat,
	input logic               out_last
);

	// commands taken whose last unit has not gone out yet
	logic [7:0] pending_q;
	logic       cmd_in;
	logic       last_out;

	assign cmd_in   = cmd_valid && cmd_ready && (cmd_action != ACT_NONE);
	assign last_out = out_valid && out_ready && out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (cmd_in && !last_out) begin
			pending_q <= (pending_q == 8'hff) ? pending_q : pending_q + 1'b1;
		end else if (last_out && !cmd_in) begin
			pending_q <= (pending_q == '0) ? pending_q : pending_q - 1'b1;
		end
	end

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("unit valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_level) && $stable(out_repeat)
			&& $stable(out_last))
		else $error("unit payload changed while stalled");

	a_last_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		last_out |-> (pending_q != '0) || cmd_in)
		else $error("last unit without a pending command");

	a_full_means_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> out_valid)
		else $error("command side stalled while no unit is offered");

endmodule

bind tape_bit_cell_serializer tbcs_checker u_tbcs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.cmd_action (cmd.action),
	.out_valid  (units.valid),
	.out_ready  (units.ready),
	.out_level  (units.level),
	.out_repeat (units.repeat_res),
	.out_last   (units.last)
);

FILE: sim/tape_unit_checker.sv
`timescale 1ns / 1ps

module tape_unit_checker import tbcs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	tbcs_cmd_if   cmd,
	tbcs_unit_if  units,
	tbcs_cfg_if   cfg,
	output int    errors,
	output int    pending
);

	localparam int PRINT_CAP = 100;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [SPEED_W-1:0] reps;
		logic               last;
	} tape_unit_t;

	// shadow copy of the level and speed registers
	logic [LEVEL_W-1:0] low_shadow;
	logic [LEVEL_W-1:0] high_shadow;
	logic [SPEED_W-1:0] speed_shadow;

	tape_unit_t expected_units[$];
	int         unit_count;

	task automatic report_mismatch(string msg);
		if (errors < PRINT_CAP) begin
			$display("%0t ns unit %0d: %s", $time, unit_count, msg);
		end
		errors++;
	endtask

	task automatic push_unit(bit hi, bit fin);
		tape_unit_t u;
		u.level = hi ? high_shadow : low_shadow;
		u.reps  = speed_shadow;
		u.last  = fin;
		expected_units.push_back(u);
	endtask

	// one bit cell: a one is low,high,low,high and a zero is low,low,high,high
	task automatic push_cell(bit one, bit fin);
		push_unit(1'b0, 1'b0);
		push_unit(one, 1'b0);
		push_unit(!one, 1'b0);
		push_unit(1'b1, fin);
	endtask

	task automatic serialize_command(tbcs_action_t act, logic [DATA_W-1:0] b);
		case (act)
			ACT_BYTE: begin
				push_cell(1'b0, 1'b0);
				for (int i = 0; i < DATA_W; i++) begin
					push_cell(b[i], 1'b0);
				end
				push_cell(1'b1, 1'b0);
				push_cell(1'b1, 1'b1);
			end
			ACT_PILOT: begin
				push_unit(1'b0, 1'b0);
				push_unit(1'b1, 1'b1);
			end
			ACT_PAUSE: begin
				push_unit(1'b0, 1'b0);
				push_unit(1'b0, 1'b1);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		tape_unit_t want;
		if (!arst_n) begin
			low_shadow   = LOW_LEVEL_RST;
			high_shadow  = HIGH_LEVEL_RST;
			speed_shadow = SPEED_RST;
			expected_units.delete();
			errors       = 0;
			unit_count   = 0;
		end else begin
			if (units.valid && units.ready) begin
				if (expected_units.size() == 0) begin
					report_mismatch($sformatf("unexpected unit, level %0d", units.level));
				end else begin
					want = expected_units.pop_front();
					if (units.level !== want.level) begin
						report_mismatch($sformatf("level %0d, want %0d",
							units.level, want.level));
					end
					if (units.repeat_res !== want.reps) begin
						report_mismatch($sformatf("repeat_res %0d, want %0d",
							units.repeat_res, want.reps));
					end
					if (units.last !== want.last) begin
						report_mismatch($sformatf("last %0b, want %0b",
							units.last, want.last));
					end
				end
				unit_count++;
			end
			if (cmd.valid && cmd.ready) begin
				serialize_command(tbcs_action_t'(cmd.action), cmd.data_byte);
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_LOW_LEVEL:  low_shadow   = cfg.data;
					REG_HIGH_LEVEL: high_shadow  = cfg.data;
					REG_SPEED:      speed_shadow = cfg.data[SPEED_W-1:0];
					default: ;
				endcase
			end
		end
		pending = expected_units.size();
	end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import tbcs_pkg::*;

	// write to the unused register index, must leave every register alone
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int IDLE_PCT       = 38;
	localparam int DRAIN_CYCLES   = 20;    // idle time after the last expected unit has gone out
	localparam int HOLD_CYCLES    = 300;   // long receiver hold-off, fills the queue
	localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction at all
	localparam int RANDOM_PHASES  = 4;
	localparam int PHASE_ITEMS    = 35;

	logic clk;
	logic arst_n;

	tbcs_cmd_if  cmd();
	tbcs_unit_if units();
	tbcs_cfg_if  cfg();

	int errors;
	int pending;
	int idle_pct = IDLE_PCT;
	int hold_req = 0;
	int quiet_cycles = 0;

	tape_bit_cell_serializer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.units  (units),
		.cfg    (cfg)
	);

	tape_unit_checker u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.units   (units),
		.cfg     (cfg),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// unit receiver: random ready, plus a long hold-off whenever hold_req moves
	initial begin : unit_sink
		int served;
		served = 0;
		units.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != served) begin
				served = hold_req;
				units.ready <= 1'b0;
				// count the hold-off here, the sender keeps offering meanwhile
				for (int n = 1; n < HOLD_CYCLES; n++) begin
					@(negedge clk);
				end
			end else begin
				units.ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// watchdog: any transaction on any channel restarts the count
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (units.valid && units.ready) ||
				(cfg.valid && cfg.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// offer one command, with random idle cycles in front of it;
	// valid stays high afterwards so back-to-back commands need no extra edge
	task automatic send_cmd(tbcs_action_t act, logic [DATA_W-1:0] b);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			cmd.valid <= 1'b0;
		end
		@(negedge clk);
		cmd.valid     <= 1'b1;
		cmd.action    <= act;
		cmd.data_byte <= b;
		do @(posedge clk); while (!cmd.ready);
	endtask

	// mostly bytes, some pilot and pause cycles, a few unused codes
	task automatic send_random_cmd();
		int pick;
		tbcs_action_t act;
		pick = $urandom_range(99);
		if (pick < 70) begin
			act = ACT_BYTE;
		end else if (pick < 83) begin
			act = ACT_PILOT;
		end else if (pick < 95) begin
			act = ACT_PAUSE;
		end else begin
			act = ACT_NONE;
		end
		send_cmd(act, DATA_W'($urandom_range(255)));
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// speed upper data bits are random, the block keeps only the low nibble
	task automatic configure(logic [LEVEL_W-1:0] low, logic [LEVEL_W-1:0] high,
			logic [SPEED_W-1:0] spd);
		write_reg(REG_LOW_LEVEL, low);
		write_reg(REG_HIGH_LEVEL, high);
		write_reg(REG_SPEED, {4'($urandom_range(15)), spd});
	endtask

	// stop offering, wait for every expected unit, then idle for DRAIN_CYCLES
	task automatic settle();
		@(negedge clk);
		cmd.valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		arst_n        = 1'b0;
		cmd.valid     = 1'b0;
		cmd.action    = ACT_BYTE;
		cmd.data_byte = '0;
		cfg.valid     = 1'b0;
		cfg.index     = REG_LOW_LEVEL;
		cfg.data      = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// reset levels: data extremes, single bits at both ends, all commands,
		// the unused action code, and data bytes on pilot and pause
		send_cmd(ACT_BYTE, 8'h00);
		send_cmd(ACT_BYTE, 8'hFF);
		send_cmd(ACT_BYTE, 8'h01);
		send_cmd(ACT_BYTE, 8'h80);
		send_cmd(ACT_BYTE, 8'hA5);
		send_cmd(ACT_PILOT, 8'hFF);
		send_cmd(ACT_PAUSE, 8'h5A);
		send_cmd(ACT_NONE, 8'hFF);
		send_cmd(ACT_PAUSE, 8'h00);
		send_cmd(ACT_PILOT, 8'h00);
		send_cmd(ACT_BYTE, 8'h5A);
		settle();

		// swapped levels at the extremes, top speed, then the unused register
		configure(8'hFF, 8'h00, 4'd15);
		write_reg(REG_UNUSED, 8'hFF);
		send_cmd(ACT_BYTE, 8'h3C);
		send_cmd(ACT_PILOT, 8'hA5);
		send_cmd(ACT_PAUSE, 8'hFF);
		send_cmd(ACT_NONE, 8'h00);
		settle();

		// speed of zero goes straight through to repeat_res
		configure(8'h00, 8'hFF, 4'd0);
		send_cmd(ACT_BYTE, 8'hC3);
		send_cmd(ACT_PILOT, 8'h0F);
		settle();

		// speed of one, alternating level patterns
		configure(8'h55, 8'hAA, 4'd1);
		send_cmd(ACT_BYTE, 8'h96);
		send_cmd(ACT_PAUSE, 8'hF0);
		settle();

		// random part, new register settings per phase
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			configure(LEVEL_W'($urandom_range(255)), LEVEL_W'($urandom_range(255)),
				SPEED_W'($urandom_range(15, 1)));
			// one phase runs with no idling on either side
			idle_pct = (phase == 1) ? 0 : IDLE_PCT;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver hold-off while commands keep coming
				if (phase == 2 && n == 4) begin
					hold_req++;
				end
				send_random_cmd();
			end
			settle();
		end

		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/tbcs_pkg.sv
rtl/tbcs_cmd_if.sv
rtl/tbcs_unit_if.sv
rtl/tbcs_cfg_if.sv
rtl/tbcs_front.sv
rtl/tbcs_queue.sv
rtl/tbcs_back.sv
rtl/tape_bit_cell_serializer.sv
rtl/tbcs_checker.sv
sim/tape_unit_checker.sv
sim/tb_top.sv
